/* sv/http_request_completeness_probe_macros.svh */
`ifndef HTTP_REQUEST_COMPLETENESS_PROBE_MACROS_SVH
`define HTTP_REQUEST_COMPLETENESS_PROBE_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define HRCP_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a condition in one cycle leads to another in the next cycle.
`define HRCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/hrcp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hrcp_pkg;

    localparam int CAP_W = 24;
    localparam int ACC_W = CAP_W + 1;
    localparam logic [CAP_W-1:0] CAP_RESET = 24'd65536;

    localparam logic [1:0] STATUS_NEED_MORE = 2'd0;
    localparam logic [1:0] STATUS_DONE      = 2'd1;
    localparam logic [1:0] STATUS_ERROR     = 2'd2;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       request_start;
    } hrcp_in_t;

    typedef struct packed {
        logic [1:0]       parse_status;
        logic [CAP_W-1:0] header_end_pos;
        logic [CAP_W-1:0] body_length;
    } hrcp_out_t;

    // Length information after the current byte has been applied.
    typedef struct packed {
        logic             decided;
        logic             valid;
        logic             negative;
        logic [ACC_W-1:0] value;
    } hrcp_len_t;

endpackage

`default_nettype wire

/* sv/hrcp_line_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

module hrcp_line_parser
    import hrcp_pkg::*;
#(
    parameter int VALUE_BUF_BYTES = 32
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire hrcp_in_t         item,
    input  wire logic             scan_open,
    input  wire logic [CAP_W-1:0] cap,
    output hrcp_len_t             len_info
);

    localparam int RAW_W = $clog2(VALUE_BUF_BYTES + 1);
    localparam logic [RAW_W-1:0] RAW_MAX = RAW_W'(VALUE_BUF_BYTES);
    localparam logic [3:0] NAME_LEN = 4'd14;
    localparam int PROD_W = ACC_W + 4;

    localparam logic [1:0] PH_NAME  = 2'd0;
    localparam logic [1:0] PH_SKIP  = 2'd1;
    localparam logic [1:0] PH_LEAD  = 2'd2;
    localparam logic [1:0] PH_VALUE = 2'd3;

    typedef struct packed {
        logic [1:0]       phase;
        logic [3:0]       name_idx;
        logic             decided;
        logic [ACC_W-1:0] acc;
        logic             sign_seen;
        logic             negative;
        logic             digits;
        logic             stopped;
        logic             valid;
        logic [RAW_W-1:0] trimmed;
        logic [RAW_W-1:0] raw;
    } lp_state_t;

    localparam lp_state_t LP_CLEAR = '{
        phase: PH_NAME, name_idx: 4'd0, decided: 1'b0, acc: '0, sign_seen: 1'b0,
        negative: 1'b0, digits: 1'b0, stopped: 1'b0, valid: 1'b0,
        trimmed: '0, raw: '0
    };

    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "c";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "l";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    lp_state_t state_reg;
    lp_state_t state_next;
    lp_state_t cur;

    logic [7:0]        b;
    logic [7:0]        lower;
    logic              is_blank;
    logic              is_digit;
    logic              is_space;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] lim;
    logic              take_value;

    assign b        = item.data_byte;
    assign lower    = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    assign is_blank = (b == " ") || (b == 8'h09);
    assign is_digit = (b >= "0") && (b <= "9");
    assign is_space = (b == " ") || (b >= 8'h09 && b <= 8'h0D);
    assign prod     = {cur.acc, 3'b000} + {2'b00, cur.acc, 1'b0} + PROD_W'(b - "0");
    assign lim      = PROD_W'(cap) + PROD_W'(1);

    always_comb
    begin
        cur        = item.request_start ? LP_CLEAR : state_reg;
        state_next = cur;
        take_value = 1'b0;
        if (scan_open && !cur.decided)
        begin
            if (b == CHAR_CR || b == CHAR_LF)
            begin
                if (cur.phase == PH_LEAD || cur.phase == PH_VALUE)
                begin
                    state_next.decided = 1'b1;
                    state_next.valid   = (cur.trimmed < RAW_MAX) && cur.digits;
                end
                state_next.phase    = PH_NAME;
                state_next.name_idx = 4'd0;
            end
            else
            begin
                unique case (cur.phase)
                    PH_NAME:
                    begin
                        if (cur.name_idx < NAME_LEN)
                        begin
                            if (lower == name_char(cur.name_idx))
                                state_next.name_idx = cur.name_idx + 4'd1;
                            else
                                state_next.phase = PH_SKIP;
                        end
                        else
                        begin
                            state_next.phase = (b == CHAR_COLON) ? PH_LEAD : PH_SKIP;
                        end
                    end
                    PH_LEAD:
                    begin
                        if (!is_blank)
                        begin
                            state_next.phase = PH_VALUE;
                            take_value       = 1'b1;
                        end
                    end
                    PH_VALUE: take_value = 1'b1;
                    PH_SKIP:  ;
                endcase
            end
        end

        if (take_value)
        begin
            if (cur.raw < RAW_MAX)
                state_next.raw = cur.raw + RAW_W'(1);
            if (!is_blank)
                state_next.trimmed = state_next.raw;
            // Number parsing follows strtoul: blanks, one sign, then digits.
            if (!cur.stopped)
            begin
                priority if (is_digit)
                begin
                    state_next.acc    = (prod > lim) ? lim[ACC_W-1:0] : prod[ACC_W-1:0];
                    state_next.digits = 1'b1;
                end
                else if (!cur.sign_seen && !cur.digits && is_space)
                begin
                end
                else if (!cur.sign_seen && !cur.digits && (b == "+" || b == "-"))
                begin
                    state_next.sign_seen = 1'b1;
                    state_next.negative  = (b == "-");
                end
                else
                begin
                    state_next.stopped = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= LP_CLEAR;
        else if (step)
            state_reg <= state_next;
    end

    assign len_info.decided  = state_next.decided;
    assign len_info.valid    = state_next.valid;
    assign len_info.negative = state_next.negative;
    assign len_info.value    = state_next.acc;

endmodule

`default_nettype wire

/* sv/hrcp_frame_check.sv */
`timescale 1ns / 1ps
`default_nettype none

module hrcp_frame_check
    import hrcp_pkg::*;
#(
    parameter int LENGTH_BITS = 24
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire hrcp_in_t         item,
    input  wire logic [CAP_W-1:0] cap,
    input  wire hrcp_len_t        len_info,
    output logic                  scan_open,
    output hrcp_out_t             result_next
);

    localparam int CMP_W = (LENGTH_BITS > ACC_W) ? LENGTH_BITS : ACC_W;
    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

    localparam logic [1:0] MARK_IDLE    = 2'd0;
    localparam logic [1:0] MARK_CR      = 2'd1;
    localparam logic [1:0] MARK_CRLF    = 2'd2;
    localparam logic [1:0] MARK_CRLFCR  = 2'd3;

    logic [LENGTH_BITS-1:0] byte_count_reg, byte_count_next, count_cur;
    logic [1:0]             marker_reg, marker_next, marker_cur;
    logic [LENGTH_BITS-1:0] header_end_reg, header_end_next, header_end_cur;
    logic                   found_reg, found_next, found_cur;

    logic [CMP_W-1:0] count_x;
    logic [CMP_W-1:0] body_seen_x;
    logic [CMP_W-1:0] cap_x;
    logic [CMP_W-1:0] value_x;
    logic             over_cap;

    // A transaction with request_start sees cleared state before its byte.
    assign count_cur      = item.request_start ? '0 : byte_count_reg;
    assign marker_cur     = item.request_start ? MARK_IDLE : marker_reg;
    assign header_end_cur = item.request_start ? '0 : header_end_reg;
    assign found_cur      = item.request_start ? 1'b0 : found_reg;
    assign scan_open      = !found_cur;

    assign byte_count_next = (count_cur == COUNT_MAX) ? count_cur
                                                      : count_cur + LENGTH_BITS'(1);

    always_comb
    begin
        marker_next     = marker_cur;
        header_end_next = header_end_cur;
        found_next      = found_cur;
        if (!found_cur)
        begin
            priority if (item.data_byte == CHAR_CR)
            begin
                marker_next = (marker_cur == MARK_CRLF) ? MARK_CRLFCR : MARK_CR;
            end
            else if (item.data_byte == CHAR_LF)
            begin
                if (marker_cur == MARK_CRLFCR)
                begin
                    found_next      = 1'b1;
                    header_end_next = byte_count_next;
                    marker_next     = MARK_IDLE;
                end
                else
                begin
                    marker_next = (marker_cur == MARK_CR) ? MARK_CRLF : MARK_IDLE;
                end
            end
            else
            begin
                marker_next = MARK_IDLE;
            end
        end
    end

    assign count_x     = CMP_W'(byte_count_next);
    assign body_seen_x = CMP_W'(byte_count_next - header_end_next);
    assign cap_x       = CMP_W'(cap);
    assign value_x     = CMP_W'(len_info.value);
    assign over_cap    = count_x >= cap_x;

    always_comb
    begin
        result_next.header_end_pos = '0;
        result_next.body_length    = '0;
        if (!found_next)
        begin
            result_next.parse_status = over_cap ? STATUS_ERROR : STATUS_NEED_MORE;
        end
        else
        begin
            result_next.header_end_pos = CAP_W'(CMP_W'(header_end_next));
            if (len_info.decided && len_info.valid)
            begin
                if (value_x > cap_x || (len_info.negative && value_x != '0))
                begin
                    result_next.parse_status = STATUS_ERROR;
                end
                else
                begin
                    result_next.body_length = len_info.value[CAP_W-1:0];
                    priority if (body_seen_x >= value_x)
                        result_next.parse_status = STATUS_DONE;
                    else if (over_cap)
                        result_next.parse_status = STATUS_ERROR;
                    else
                        result_next.parse_status = STATUS_NEED_MORE;
                end
            end
            else
            begin
                result_next.parse_status = STATUS_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            marker_reg     <= MARK_IDLE;
            header_end_reg <= '0;
            found_reg      <= 1'b0;
        end
        else if (step)
        begin
            byte_count_reg <= byte_count_next;
            marker_reg     <= marker_next;
            header_end_reg <= header_end_next;
            found_reg      <= found_next;
        end
    end

endmodule

`default_nettype wire

/* sv/http_request_completeness_probe.sv */
`timescale 1ns / 1ps
`default_nettype none

// Streaming HTTP/1.1 request completeness probe. Each accepted transaction on
// the request channel carries one request byte and yields exactly one result
// transaction: the status of the prefix seen so far (need more, done, error),
// the position just after the CR LF CR LF marker, and the declared body length.
// Throughput is one byte per clock cycle unless result_ready stalls the output. An
// accepted byte sits in the input register while the header-line parser and
// the frame checker work on it; the result register loads when the byte leaves
// the input register, and the byte stays there while a result waits to be taken.
// Setting request_start on a byte clears all parse state before that byte.
// The user must write buffer_cap only while no transaction is in flight;
// the block does not enforce this. There is no clearing pass after reset.

`include "http_request_completeness_probe_macros.svh"

module http_request_completeness_probe
    import hrcp_pkg::*;
#(
    parameter int LENGTH_BITS     = 24,
    parameter int VALUE_BUF_BYTES = 32
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             buffer_cap_wr_en,
    input  wire logic [CAP_W-1:0] buffer_cap_wr_data,
    input  wire logic             request_valid,
    output logic                  request_ready,
    input  wire hrcp_in_t         request_item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output hrcp_out_t             result_item
);

    localparam logic [CAP_W-1:0] CAP_MASK =
        (LENGTH_BITS >= CAP_W) ? '1 : CAP_W'((64'd1 << LENGTH_BITS) - 64'd1);

    logic [CAP_W-1:0] cap_reg;
    logic             in_valid_reg;
    hrcp_in_t         in_reg;
    logic             out_valid_reg;
    hrcp_out_t        out_reg;

    logic      out_advance;
    logic      step;
    logic      scan_open;
    hrcp_len_t len_info;
    hrcp_out_t result_next;
    logic      in_stall;
    logic      out_status_ok;

    assign out_advance   = !out_valid_reg || result_ready;
    assign step          = in_valid_reg && out_advance;
    assign request_ready = !in_valid_reg || out_advance;
    assign result_valid  = out_valid_reg;
    assign result_item   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET & CAP_MASK;
        else if (buffer_cap_wr_en)
            cap_reg <= buffer_cap_wr_data & CAP_MASK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (request_ready)
                in_valid_reg <= request_valid;
            if (out_advance)
                out_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (request_valid && request_ready)
            in_reg <= request_item;
        if (step)
            out_reg <= result_next;
    end

    hrcp_line_parser #(
        .VALUE_BUF_BYTES (VALUE_BUF_BYTES)
    ) u_line_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (in_reg),
        .scan_open (scan_open),
        .cap       (cap_reg),
        .len_info  (len_info)
    );

    hrcp_frame_check #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_frame_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (in_reg),
        .cap         (cap_reg),
        .len_info    (len_info),
        .scan_open   (scan_open),
        .result_next (result_next)
    );

    assign in_stall      = in_valid_reg && !step;
    assign out_status_ok = (out_reg.parse_status == STATUS_NEED_MORE) ||
                           (out_reg.parse_status == STATUS_DONE) ||
                           (out_reg.parse_status == STATUS_ERROR);

    // A byte that moves out of the input register always lands as a result.
    `HRCP_ASSERT_NEXT(a_step_lands, step, out_valid_reg, "processed byte produced no result")
    // A byte held in the input register is neither dropped nor altered.
    `HRCP_ASSERT_NEXT(a_input_held, in_stall, in_valid_reg && $stable(in_reg), "stalled input lost")
    // Results only ever carry one of the three status codes.
    `HRCP_ASSERT_ALWAYS(a_status_code, !out_valid_reg || out_status_ok, "undefined status code")

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import hrcp_pkg::*;

    typedef logic [7:0] octet_t;
    typedef enum logic [1:0] {LINE_NAME, LINE_SKIP, LINE_LEAD, LINE_VALUE} line_state_t;

    localparam int     NAME_LEN     = 14;
    localparam int     VALUE_MAX    = 32;
    localparam int     PHASE_COUNT  = 6;
    localparam int     PHASE_BYTES  = 205;
    localparam int     DRAIN_CYCLES = 8;
    localparam octet_t CHAR_SP      = 8'h20;
    localparam octet_t CHAR_TAB     = 8'h09;
    localparam octet_t CHAR_PLUS    = 8'h2B;
    localparam octet_t CHAR_MINUS   = 8'h2D;
    localparam octet_t CHAR_ZERO    = 8'h30;
    localparam octet_t CHAR_NINE    = 8'h39;
    localparam octet_t FIELD_NAME [NAME_LEN] =
        '{"c", "o", "n", "t", "e", "n", "t", "-", "l", "e", "n", "g", "t", "h"};

    typedef struct {
        octet_t           data;
        logic             start;
        logic             typed;
        logic [1:0]       status;
        logic [CAP_W-1:0] hend;
        logic [CAP_W-1:0] body;
    } dir_row_t;

    // Bare marker, bytes after it, a single-byte request, then a mixed-case
    // length header carrying a negative value.
    localparam int DIR_ROWS = 27;
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{CHAR_CR, 1'b1, 1'b1, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{CHAR_LF, 1'b0, 1'b1, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{CHAR_CR, 1'b0, 1'b1, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{CHAR_LF, 1'b0, 1'b1, STATUS_DONE, 24'd4, 24'd0},
        '{8'hFF, 1'b0, 1'b1, STATUS_DONE, 24'd4, 24'd0},
        '{8'h00, 1'b1, 1'b1, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{"C", 1'b1, 1'b0, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{"o", 1'b0, 1'b0, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{"n", 1'b0, 1'b0, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{"t", 1'b0, 1'b0, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{"e", 1'b0, 1'b0, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{"n", 1'b0, 1'b0, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{"t", 1'b0, 1'b0, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{"-", 1'b0, 1'b0, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{"L", 1'b0, 1'b0, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{"E", 1'b0, 1'b0, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{"N", 1'b0, 1'b0, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{"G", 1'b0, 1'b0, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{"T", 1'b0, 1'b0, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{"H", 1'b0, 1'b0, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{CHAR_COLON, 1'b0, 1'b0, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{CHAR_MINUS, 1'b0, 1'b0, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{"1", 1'b0, 1'b0, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{CHAR_CR, 1'b0, 1'b0, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{CHAR_LF, 1'b0, 1'b0, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{CHAR_CR, 1'b0, 1'b0, STATUS_NEED_MORE, 24'd0, 24'd0},
        '{CHAR_LF, 1'b0, 1'b1, STATUS_ERROR, 24'd21, 24'd0}
    };

    logic             clk;
    logic             rst_n;
    logic             buffer_cap_wr_en;
    logic [CAP_W-1:0] buffer_cap_wr_data;
    logic             request_valid;
    logic             request_ready;
    hrcp_in_t         request_item;
    logic             result_valid;
    logic             result_ready;
    hrcp_out_t        result_item;

    hrcp_out_t pending_verdicts [$];
    octet_t    req_bytes [$];
    int        fail_count = 0;
    int        send_idle_pct;
    int        recv_idle_pct;

    // Shadow copy of the capacity register and of the framing state.
    logic [CAP_W-1:0] cap_setting;
    logic [CAP_W-1:0] byte_total;
    logic [1:0]       crlf_seen;
    logic [CAP_W-1:0] hdr_end;
    logic             hdr_seen;
    line_state_t      line_state;
    logic [3:0]       name_pos;
    logic             len_fixed;
    logic [ACC_W-1:0] num_acc;
    logic             sign_seen;
    logic             num_neg;
    logic             digits_seen;
    logic             num_stopped;
    logic             len_ok;
    logic [5:0]       trim_len;
    logic [5:0]       raw_len;

    http_request_completeness_probe u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .buffer_cap_wr_en   (buffer_cap_wr_en),
        .buffer_cap_wr_data (buffer_cap_wr_data),
        .request_valid      (request_valid),
        .request_ready      (request_ready),
        .request_item       (request_item),
        .result_valid       (result_valid),
        .result_ready       (result_ready),
        .result_item        (result_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void clear_probe();
        byte_total  = '0;
        crlf_seen   = '0;
        hdr_end     = '0;
        hdr_seen    = 1'b0;
        line_state  = LINE_NAME;
        name_pos    = '0;
        len_fixed   = 1'b0;
        num_acc     = '0;
        sign_seen   = 1'b0;
        num_neg     = 1'b0;
        digits_seen = 1'b0;
        num_stopped = 1'b0;
        len_ok      = 1'b0;
        trim_len    = '0;
        raw_len     = '0;
    endfunction

    function automatic logic is_blank(input octet_t b);
        return (b == CHAR_SP) || (b == CHAR_TAB);
    endfunction

    // Base-10 conversion in the manner of strtoul, saturating one above the capacity.
    function automatic void number_char(input octet_t b);
        longint unsigned sum;
        longint unsigned lim;
        if (num_stopped)
            return;
        if (b >= CHAR_ZERO && b <= CHAR_NINE)
        begin
            lim = 64'(cap_setting) + 64'd1;
            sum = 64'(num_acc) * 64'd10 + 64'(b - CHAR_ZERO);
            num_acc = (sum > lim) ? lim[ACC_W-1:0] : sum[ACC_W-1:0];
            digits_seen = 1'b1;
        end
        else if (!sign_seen && !digits_seen && (b == CHAR_SP || (b >= 8'd9 && b <= 8'd13)))
        begin
            // Leading white space is skipped.
        end
        else if (!sign_seen && !digits_seen && (b == CHAR_PLUS || b == CHAR_MINUS))
        begin
            sign_seen = 1'b1;
            num_neg   = (b == CHAR_MINUS);
        end
        else
            num_stopped = 1'b1;
    endfunction

    function automatic void value_char(input octet_t b);
        if (raw_len < VALUE_MAX)
            raw_len = raw_len + 6'd1;
        if (!is_blank(b))
            trim_len = raw_len;
        number_char(b);
    endfunction

    function automatic void line_char(input octet_t b);
        octet_t c;
        if (b == CHAR_CR || b == CHAR_LF)
        begin
            if (line_state == LINE_LEAD || line_state == LINE_VALUE)
            begin
                len_fixed = 1'b1;
                len_ok    = (trim_len < VALUE_MAX) && digits_seen;
            end
            line_state = LINE_NAME;
            name_pos   = '0;
            return;
        end
        case (line_state)
            LINE_NAME:
            begin
                c = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
                if (name_pos < NAME_LEN)
                begin
                    if (c == FIELD_NAME[name_pos])
                        name_pos = name_pos + 4'd1;
                    else
                        line_state = LINE_SKIP;
                end
                else
                    line_state = (b == CHAR_COLON) ? LINE_LEAD : LINE_SKIP;
            end
            LINE_LEAD:
            begin
                if (!is_blank(b))
                begin
                    line_state = LINE_VALUE;
                    value_char(b);
                end
            end
            LINE_VALUE:
                value_char(b);
            default:
                ;
        endcase
    endfunction

    // Verdict for the request prefix after one more byte.
    function automatic hrcp_out_t probe_byte(input hrcp_in_t it);
        hrcp_out_t        r;
        octet_t           b;
        logic [CAP_W-1:0] body_seen;
        b = it.data_byte;
        r = '0;
        if (it.request_start)
            clear_probe();
        if (byte_total != {CAP_W{1'b1}})
            byte_total = byte_total + 1'b1;
        if (!hdr_seen)
        begin
            if (!len_fixed)
                line_char(b);
            if (b == CHAR_CR)
                crlf_seen = (crlf_seen == 2'd2) ? 2'd3 : 2'd1;
            else if (b == CHAR_LF)
            begin
                if (crlf_seen == 2'd3)
                begin
                    hdr_seen  = 1'b1;
                    hdr_end   = byte_total;
                    crlf_seen = 2'd0;
                end
                else
                    crlf_seen = (crlf_seen == 2'd1) ? 2'd2 : 2'd0;
            end
            else
                crlf_seen = 2'd0;
        end
        if (!hdr_seen)
            r.parse_status = (byte_total >= cap_setting) ? STATUS_ERROR : STATUS_NEED_MORE;
        else
        begin
            r.header_end_pos = hdr_end;
            r.parse_status   = STATUS_DONE;
            if (len_fixed && len_ok)
            begin
                if (num_acc > {1'b0, cap_setting} || (num_neg && num_acc != '0))
                    r.parse_status = STATUS_ERROR;
                else
                begin
                    r.body_length = num_acc[CAP_W-1:0];
                    body_seen = byte_total - hdr_end;
                    if ({1'b0, body_seen} >= num_acc)
                        r.parse_status = STATUS_DONE;
                    else if (byte_total >= cap_setting)
                        r.parse_status = STATUS_ERROR;
                    else
                        r.parse_status = STATUS_NEED_MORE;
                end
            end
        end
        return r;
    endfunction

    task automatic offer_byte(input hrcp_in_t it, input logic typed, input hrcp_out_t fixed);
        hrcp_out_t guess;
        while ($urandom_range(99) < send_idle_pct)
        begin
            request_valid <= 1'b0;
            @(negedge clk);
        end
        request_valid <= 1'b1;
        request_item  <= it;
        do
            @(posedge clk);
        while (!request_ready);
        guess = probe_byte(it);
        pending_verdicts.push_back(typed ? fixed : guess);
        @(negedge clk);
    endtask

    task automatic wait_for_verdicts();
        request_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        buffer_cap_wr_en   <= 1'b1;
        buffer_cap_wr_data <= cap;
        @(negedge clk);
        buffer_cap_wr_en <= 1'b0;
        cap_setting = cap;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            req_bytes.push_back(octet_t'(s[i]));
    endtask

    task automatic put_blank();
        req_bytes.push_back($urandom_range(1) ? CHAR_SP : CHAR_TAB);
    endtask

    // Mostly CR LF; sometimes a line end that cannot form the marker.
    task automatic put_eol();
        case ($urandom_range(19))
            0: req_bytes.push_back(CHAR_LF);
            1: req_bytes.push_back(CHAR_CR);
            2:
            begin
                req_bytes.push_back(CHAR_CR);
                req_bytes.push_back(CHAR_CR);
                req_bytes.push_back(CHAR_LF);
            end
            default:
            begin
                req_bytes.push_back(CHAR_CR);
                req_bytes.push_back(CHAR_LF);
            end
        endcase
    endtask

    task automatic put_length_line(output longint decl);
        octet_t c;
        string  digits;
        int     n;
        int     bad_pos;
        decl = -1;
        // Random letter case; now and then one character of the name is wrong.
        bad_pos = ($urandom_range(9) == 0) ? int'($urandom_range(NAME_LEN - 1)) : NAME_LEN;
        for (int i = 0; i < NAME_LEN; i++)
        begin
            c = FIELD_NAME[i];
            if (i == bad_pos)
                c = octet_t'($urandom_range(8'h7E, 8'h21));
            if (c >= "a" && c <= "z" && $urandom_range(1) == 1)
                c = c - 8'd32;
            req_bytes.push_back(c);
        end
        case ($urandom_range(19))
            0: req_bytes.push_back(CHAR_SP);
            1: put_text("s");
            default: ;
        endcase
        req_bytes.push_back(CHAR_COLON);
        repeat ($urandom_range(2)) put_blank();
        case ($urandom_range(7))
            0:
            begin
                decl = $urandom_range(30);
                put_text($sformatf("%0d", decl));
            end
            1:
            begin
                n = $urandom_range(4);
                decl = longint'(cap_setting) + n - 2;
                if (decl < 0)
                    decl = 0;
                put_text($sformatf("%0d", decl));
            end
            2:
            begin
                // Eight or more digits, a value of at least ten million.
                req_bytes.push_back(octet_t'($urandom_range(CHAR_NINE, "1")));
                repeat ($urandom_range(20, 7))
                    req_bytes.push_back(octet_t'($urandom_range(CHAR_NINE, CHAR_ZERO)));
            end
            3:
            begin
                req_bytes.push_back($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
                decl = $urandom_range(20);
                put_text($sformatf("%0d", decl));
            end
            4:
            begin
                case ($urandom_range(3))
                    0: put_text("abc");
                    1: req_bytes.push_back(CHAR_MINUS);
                    2: put_text("+x7");
                    default: ;
                endcase
            end
            5:
            begin
                decl = $urandom_range(15);
                put_text($sformatf("%0d", decl));
                put_text($urandom_range(1) ? "x9" : " 7");
            end
            6:
            begin
                // Leading zeros put the value length on either side of the buffer size.
                digits = $sformatf("%0d", $urandom_range(40));
                n = $urandom_range(35, 29) - digits.len();
                repeat (n) req_bytes.push_back(CHAR_ZERO);
                put_text(digits);
                decl = digits.atoi();
            end
            default:
            begin
                case ($urandom_range(2))
                    0: req_bytes.push_back(8'h0B);
                    1: req_bytes.push_back(8'h0C);
                    default: req_bytes.push_back(CHAR_SP);
                endcase
                if ($urandom_range(1) == 1)
                    req_bytes.push_back(CHAR_PLUS);
                if ($urandom_range(3) == 0)
                    req_bytes.push_back(CHAR_SP);
                decl = $urandom_range(12);
                put_text($sformatf("%0d", decl));
            end
        endcase
        repeat ($urandom_range(2)) put_blank();
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(40, 1)) put_blank();
        put_eol();
    endtask

    task automatic put_other_line();
        case ($urandom_range(5))
            0: put_text("Host: example");
            1: put_text("X-Content-Length: 3");
            2: put_text("Content-Type: 12");
            3: ;
            4:
            begin
                repeat ($urandom_range(10, 1))
                    req_bytes.push_back(octet_t'($urandom_range(8'h7E, 8'h20)));
            end
            default:
            begin
                repeat ($urandom_range(6, 1))
                    req_bytes.push_back(octet_t'($urandom_range(255)));
            end
        endcase
        put_eol();
    endtask

    task automatic compose_request();
        longint decl;
        longint spare;
        int     lines;
        int     where;
        int     nbody;
        req_bytes.delete();
        decl = -1;
        if ($urandom_range(99) < 12)
        begin
            repeat ($urandom_range(12, 1))
                req_bytes.push_back(octet_t'($urandom_range(255)));
            return;
        end
        if ($urandom_range(9) < 7)
        begin
            put_text("GET / HTTP/1.1");
            put_eol();
        end
        lines = $urandom_range(3);
        where = $urandom_range(lines + 1);
        for (int i = 0; i <= lines; i++)
        begin
            if (i == where)
                put_length_line(decl);
            else
                put_other_line();
        end
        // A later length line must not override the first one.
        if ($urandom_range(5) == 0)
            put_length_line(spare);
        if ($urandom_range(9) != 0)
        begin
            req_bytes.push_back(CHAR_CR);
            req_bytes.push_back(CHAR_LF);
        end
        if (decl >= 0 && decl <= 24)
            nbody = ($urandom_range(3) == 0) ? int'($urandom_range(int'(decl)))
                                             : int'(decl) + int'($urandom_range(2));
        else
            nbody = $urandom_range(16);
        repeat (nbody) req_bytes.push_back(octet_t'($urandom_range(255)));
    endtask

    always @(negedge clk)
        result_ready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic void check_field(input string what, input logic [CAP_W-1:0] want,
                                        input logic [CAP_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        hrcp_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: result with nothing expected: status %0d hend %0d body %0d",
                         $time, result_item.parse_status, result_item.header_end_pos,
                         result_item.body_length);
                fail_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                check_field("parse_status", CAP_W'(want.parse_status),
                            CAP_W'(result_item.parse_status));
                check_field("header_end_pos", want.header_end_pos, result_item.header_end_pos);
                check_field("body_length", want.body_length, result_item.body_length);
            end
        end
    end

    initial
    begin
        #(2_000_000);
        $display("http_request_completeness_probe regression: fail");
        $finish;
    end

    initial
    begin
        hrcp_in_t  it;
        hrcp_out_t fixed;
        int        sent;
        rst_n              = 1'b0;
        buffer_cap_wr_en   = 1'b0;
        buffer_cap_wr_data = '0;
        request_valid      = 1'b0;
        request_item       = '0;
        result_ready       = 1'b0;
        send_idle_pct      = 30;
        recv_idle_pct      = 80;
        cap_setting        = CAP_RESET;
        clear_probe();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            it.data_byte         = dir_rows[i].data;
            it.request_start     = dir_rows[i].start;
            fixed.parse_status   = dir_rows[i].status;
            fixed.header_end_pos = dir_rows[i].hend;
            fixed.body_length    = dir_rows[i].body;
            offer_byte(it, dir_rows[i].typed, fixed);
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            send_idle_pct = (p < 2) ? 30 : (p < 4) ? 80 : 0;
            recv_idle_pct = (p < 2) ? 80 : (p < 4) ? 30 : 0;
            if (p > 0)
            begin
                wait_for_verdicts();
                case (p)
                    1: set_capacity(24'd1);
                    2: set_capacity({CAP_W{1'b1}});
                    3: set_capacity(CAP_W'($urandom_range(400, 20)));
                    4: set_capacity(CAP_W'($urandom_range(24'hFFFFFF, 1)));
                    default: set_capacity(CAP_W'($urandom_range(64, 8)));
                endcase
            end
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                compose_request();
                foreach (req_bytes[k])
                begin
                    it.data_byte     = req_bytes[k];
                    it.request_start = (k == 0) || ($urandom_range(199) == 0);
                    offer_byte(it, 1'b0, '0);
                    sent++;
                end
                // Occasionally hold off until every verdict has come back.
                if ($urandom_range(99) < 3)
                    wait_for_verdicts();
            end
        end

        wait_for_verdicts();
        if (fail_count == 0)
            $display("http_request_completeness_probe regression: pass");
        else
            $display("http_request_completeness_probe regression: fail");
        $finish;
    end

endmodule
